// ===== sv/sus_pkg.sv =====
// Shared constants, codes and types for the sorted unique set.
package sus_pkg;

	// Table size and derived widths
	localparam int CAPACITY = 32;
	localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	// Field widths fixed by the item format
	localparam int OP_W     = 2;
	localparam int VAL_W    = 32;
	localparam int IDX_W    = 5;
	localparam int STAT_W   = 3;
	localparam int OCNT_W   = 6;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT = 2'd0,
		OP_REMOVE = 2'd1,
		OP_READ   = 2'd2
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_INSERTED  = 3'd0,
		STAT_DUPLICATE = 3'd1,
		STAT_REMOVED   = 3'd2,
		STAT_NOT_FOUND = 3'd3,
		STAT_FULL      = 3'd4,
		STAT_READ_OK   = 3'd5,
		STAT_BAD_INDEX = 3'd6
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_INS_SHIFT,
		ST_DEL_SHIFT,
		ST_RD_DATA,
		ST_DONE
	} state_t;

endpackage

// ===== sv/sus_if.sv =====
// Request and response channel interfaces for the sorted unique set.
interface sus_req_if;
	logic                                valid;
	logic                                ready;
	logic [sus_pkg::OP_W-1:0]            opcode;
	logic signed [sus_pkg::VAL_W-1:0]    value;
	logic [sus_pkg::IDX_W-1:0]           index;

	modport source (output valid, output opcode, output value, output index, input ready);
	modport sink   (input valid, input opcode, input value, input index, output ready);
endinterface

interface sus_rsp_if;
	logic                                valid;
	logic                                ready;
	logic [sus_pkg::STAT_W-1:0]          status;
	logic [sus_pkg::OCNT_W-1:0]          entry_count;
	logic signed [sus_pkg::VAL_W-1:0]    read_value;

	modport source (output valid, output status, output entry_count, output read_value,
		input ready);
	modport sink   (input valid, input status, input entry_count, input read_value,
		output ready);
endinterface

// ===== sv/sorted_unique_set.sv =====
// Sorted unique set: ascending table of distinct values in one synchronous memory.
// A read fetches the indexed entry through the registered read port; a bad index or an unused
// opcode goes straight to the result. Insert and remove run a linear search, then shift the
// entries above the position one slot, moving one entry per cycle, then register the result.
// The next beat is taken once the result sits in the response register, which waits while an
// earlier response stalls. One beat is in work at a time; reset empties the table at once.
module sorted_unique_set (
	input  logic         clk,
	input  logic         arst_n,
	sus_req_if.sink      req,
	sus_rsp_if.source    rsp
);
	import sus_pkg::*;

	state_t state_q, state_d;

	// Table memory and its registered read port
	logic signed [VAL_W-1:0] mem [CAPACITY];
	logic signed [VAL_W-1:0] rdata_s1;
	logic [ADDR_W-1:0]       rd_addr;
	logic                    wr_en;
	logic [ADDR_W-1:0]       wr_addr;
	logic signed [VAL_W-1:0] wr_data;

	// Read tracking for the compare and shift pipeline
	logic              rd_vld_s1, rd_vld_d;
	logic [ADDR_W-1:0] rd_pos_s1, rd_pos_d;

	// Walk control
	logic [CNT_W-1:0] ptr_q, ptr_d;
	logic [CNT_W-1:0] rem_q, rem_d;
	logic [CNT_W-1:0] pos_q, pos_d;
	logic [CNT_W-1:0] count_q, count_d;

	// Current beat
	logic [OP_W-1:0]         op_q, op_d;
	logic signed [VAL_W-1:0] value_q, value_d;
	status_t                 status_q, status_d;
	logic signed [VAL_W-1:0] rdval_q, rdval_d;

	// Response register
	logic                    rsp_valid_q, rsp_valid_d;
	status_t                 rsp_status_q, rsp_status_d;
	logic [OCNT_W-1:0]       rsp_count_q, rsp_count_d;
	logic signed [VAL_W-1:0] rsp_rdval_q, rsp_rdval_d;

	logic             req_fire;
	logic             idx_ok;
	logic             key_less;
	logic             key_match;
	logic             hit_stop;
	logic             end_stop;
	logic             search_done;
	logic             found;
	logic [CNT_W-1:0] pos_sel;
	logic             is_full;
	logic             rsp_free;

	assign req.ready = (state_q == ST_IDLE);
	assign req_fire  = req.valid && req.ready;
	assign idx_ok    = 32'(req.index) < 32'(count_q);
	assign rsp_free  = !rsp_valid_q || rsp.ready;
	assign is_full   = (count_q == CNT_W'(CAPACITY));

	// Compare the entry read last cycle against the search value
	assign key_less    = rdata_s1 < value_q;
	assign key_match   = rdata_s1 == value_q;
	assign hit_stop    = rd_vld_s1 && !key_less;
	assign end_stop    = !hit_stop && (ptr_q == count_q);
	assign search_done = hit_stop || end_stop;
	assign found       = hit_stop && key_match;
	assign pos_sel     = hit_stop ? CNT_W'(rd_pos_s1) : count_q;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_fire) begin
					case (req.opcode)
						OP_INSERT, OP_REMOVE: state_d = ST_SEARCH;
						OP_READ:              state_d = idx_ok ? ST_RD_DATA : ST_DONE;
						default:              state_d = ST_DONE;
					endcase
				end
			end
			ST_SEARCH: begin
				if (search_done) begin
					if (op_q == OP_INSERT) begin
						state_d = (found || is_full) ? ST_DONE : ST_INS_SHIFT;
					end else begin
						state_d = found ? ST_DEL_SHIFT : ST_DONE;
					end
				end
			end
			ST_INS_SHIFT: begin
				if (rem_q == '0 && !rd_vld_s1) begin
					state_d = ST_DONE;
				end
			end
			ST_DEL_SHIFT: begin
				if (rem_q == '0 && !rd_vld_s1) begin
					state_d = ST_DONE;
				end
			end
			ST_RD_DATA: state_d = ST_DONE;
			ST_DONE: begin
				if (rsp_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Datapath controls and register updates
	always_comb begin
		rd_addr     = ptr_q[ADDR_W-1:0];
		wr_en       = 1'b0;
		wr_addr     = rd_pos_s1;
		wr_data     = rdata_s1;
		rd_vld_d    = rd_vld_s1;
		rd_pos_d    = rd_pos_s1;
		ptr_d       = ptr_q;
		rem_d       = rem_q;
		pos_d       = pos_q;
		count_d     = count_q;
		op_d        = op_q;
		value_d     = value_q;
		status_d    = status_q;
		rdval_d     = rdval_q;
		rsp_valid_d = rsp_valid_q;
		rsp_status_d = rsp_status_q;
		rsp_count_d = rsp_count_q;
		rsp_rdval_d = rsp_rdval_q;

		// Drop the response once it is taken
		if (rsp_valid_q && rsp.ready) begin
			rsp_valid_d = 1'b0;
		end

		unique case (state_q)
			ST_IDLE: begin
				rd_addr = ADDR_W'(req.index);
				if (req_fire) begin
					op_d     = req.opcode;
					value_d  = req.value;
					rdval_d  = '0;
					ptr_d    = '0;
					rd_vld_d = 1'b0;
					status_d = STAT_BAD_INDEX;
				end
			end
			ST_SEARCH: begin
				if (search_done) begin
					rd_vld_d = 1'b0;
					pos_d    = pos_sel;
					if (op_q == OP_INSERT) begin
						if (found) begin
							status_d = STAT_DUPLICATE;
						end else if (is_full) begin
							status_d = STAT_FULL;
						end else begin
							rem_d = count_q - pos_sel;
							ptr_d = count_q - 1'b1;
						end
					end else begin
						if (found) begin
							rem_d = count_q - pos_sel - 1'b1;
							ptr_d = pos_sel + 1'b1;
						end else begin
							status_d = STAT_NOT_FOUND;
						end
					end
				end else begin
					// Advance the walk by one entry
					rd_vld_d = 1'b1;
					rd_pos_d = ptr_q[ADDR_W-1:0];
					ptr_d    = ptr_q + 1'b1;
				end
			end
			ST_INS_SHIFT: begin
				// Move each entry up one slot, top first
				if (rd_vld_s1) begin
					wr_en   = 1'b1;
					wr_addr = rd_pos_s1 + 1'b1;
					wr_data = rdata_s1;
				end
				if (rem_q != '0) begin
					rd_vld_d = 1'b1;
					rd_pos_d = ptr_q[ADDR_W-1:0];
					ptr_d    = ptr_q - 1'b1;
					rem_d    = rem_q - 1'b1;
				end else begin
					rd_vld_d = 1'b0;
					if (!rd_vld_s1) begin
						wr_en    = 1'b1;
						wr_addr  = pos_q[ADDR_W-1:0];
						wr_data  = value_q;
						count_d  = count_q + 1'b1;
						status_d = STAT_INSERTED;
					end
				end
			end
			ST_DEL_SHIFT: begin
				// Move each entry down one slot, bottom first
				if (rd_vld_s1) begin
					wr_en   = 1'b1;
					wr_addr = rd_pos_s1 - 1'b1;
					wr_data = rdata_s1;
				end
				if (rem_q != '0) begin
					rd_vld_d = 1'b1;
					rd_pos_d = ptr_q[ADDR_W-1:0];
					ptr_d    = ptr_q + 1'b1;
					rem_d    = rem_q - 1'b1;
				end else begin
					rd_vld_d = 1'b0;
					if (!rd_vld_s1) begin
						count_d  = count_q - 1'b1;
						status_d = STAT_REMOVED;
					end
				end
			end
			ST_RD_DATA: begin
				status_d = STAT_READ_OK;
				rdval_d  = rdata_s1;
			end
			ST_DONE: begin
				if (rsp_free) begin
					rsp_valid_d  = 1'b1;
					rsp_status_d = status_q;
					rsp_count_d  = OCNT_W'(count_q);
					rsp_rdval_d  = rdval_q;
				end
			end
			default: begin
				rd_vld_d = 1'b0;
			end
		endcase
	end

	// Hold the memory and its read register
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rdata_s1 <= mem[rd_addr];
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			rd_vld_s1   <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			count_q     <= count_d;
			rd_vld_s1   <= rd_vld_d;
			rsp_valid_q <= rsp_valid_d;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		rd_pos_s1    <= rd_pos_d;
		ptr_q        <= ptr_d;
		rem_q        <= rem_d;
		pos_q        <= pos_d;
		op_q         <= op_d;
		value_q      <= value_d;
		status_q     <= status_d;
		rdval_q      <= rdval_d;
		rsp_status_q <= rsp_status_d;
		rsp_count_q  <= rsp_count_d;
		rsp_rdval_q  <= rsp_rdval_d;
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = rsp_status_q;
	assign rsp.entry_count = rsp_count_q;
	assign rsp.read_value  = rsp_rdval_q;

endmodule

// ===== sv/sus_checker.sv =====
// Port-level assertions for the sorted unique set, bound to the top level.
module sus_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             rsp_valid,
	input logic                             rsp_ready,
	input logic [sus_pkg::STAT_W-1:0]       rsp_status,
	input logic [sus_pkg::OCNT_W-1:0]       rsp_entry_count,
	input logic signed [sus_pkg::VAL_W-1:0] rsp_read_value
);
	import sus_pkg::*;

	// Hold a stalled response beat
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
			&& $stable(rsp_entry_count) && $stable(rsp_read_value))
		else $error("response beat changed while stalled");

	// Count never passes the table size
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> 32'(rsp_entry_count) <= 32'(CAPACITY))
		else $error("entry count above capacity");

	// Only a good read carries data
	a_rdval_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status != STAT_READ_OK |-> rsp_read_value == '0)
		else $error("read value nonzero on a non-read status");

	// Full is reported only at capacity, a good read only when not empty
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == STAT_FULL |-> rsp_entry_count == OCNT_W'(CAPACITY))
		else $error("full status below capacity");

	a_read_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == STAT_READ_OK |-> rsp_entry_count != '0)
		else $error("read ok on an empty table");

endmodule

bind sorted_unique_set sus_checker u_sus_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_status      (rsp.status),
	.rsp_entry_count (rsp.entry_count),
	.rsp_read_value  (rsp.read_value)
);
